@@ sv/clcd_pkg.sv @@
// Shared types and constants for the character display text buffer.
// Holds geometry, opcodes, character limits and the sequencer microcode.
// No dependencies.
`default_nettype none

package clcd_pkg;

  localparam int unsigned ROWS  = 2;
  localparam int unsigned COLS  = 16;
  localparam int unsigned CELLS = ROWS * COLS;

  localparam int unsigned ROW_W = 1;
  localparam int unsigned COL_W = 4;
  localparam int unsigned IDX_W = 5;
  localparam int unsigned CH_W  = 8;
  localparam int unsigned OP_W  = 3;
  localparam int unsigned TROW_W = 4;
  localparam int unsigned TCOL_W = 6;

  localparam logic [CH_W-1:0] CH_LOW   = 8'd32;
  localparam logic [CH_W-1:0] CH_HIGH  = 8'd126;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE     = 3'd0,
    OP_CLEAR     = 3'd1,
    OP_CLEAR_EOL = 3'd2,
    OP_DOWN      = 3'd3,
    OP_UP        = 3'd4,
    OP_RIGHT     = 3'd5,
    OP_LEFT      = 3'd6,
    OP_SET_POS   = 3'd7
  } opcode_t;

  // Microcode step addresses
  typedef logic [1:0] step_t;
  localparam step_t STEP_IDLE   = 2'd0;
  localparam step_t STEP_EXEC   = 2'd1;
  localparam step_t STEP_DUMP   = 2'd2;
  localparam step_t STEP_STATUS = 2'd3;

  typedef enum logic [1:0] {
    COND_IN_ACC    = 2'd0,
    COND_NO_DUMP   = 2'd1,
    COND_DUMP_DONE = 2'd2,
    COND_SLOT_FREE = 2'd3
  } cond_t;

  typedef struct packed {
    logic  take_in;
    logic  exec;
    logic  emit_dump;
    logic  emit_status;
    cond_t cond;
    step_t target;
    logic  advance;   // on a false condition: 1 step ahead, 0 hold
  } ucode_t;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    w = '0;
    unique case (s)
      STEP_IDLE: begin
        w.take_in = 1'b1;
        w.cond    = COND_IN_ACC;
        w.target  = STEP_EXEC;
      end
      STEP_EXEC: begin
        w.exec    = 1'b1;
        w.cond    = COND_NO_DUMP;
        w.target  = STEP_STATUS;
        w.advance = 1'b1;
      end
      STEP_DUMP: begin
        w.emit_dump = 1'b1;
        w.cond      = COND_DUMP_DONE;
        w.target    = STEP_IDLE;
      end
      STEP_STATUS: begin
        w.emit_status = 1'b1;
        w.cond        = COND_SLOT_FREE;
        w.target      = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ sv/clcd_cmd_if.sv @@
// Command channel of the character display text buffer.
// Valid/ready handshake with the command fields; uses clcd_pkg widths.
`default_nettype none

interface clcd_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [clcd_pkg::OP_W-1:0]    opcode;
  logic [clcd_pkg::CH_W-1:0]    char_code;
  logic [clcd_pkg::TROW_W-1:0]  target_row;
  logic [clcd_pkg::TCOL_W-1:0]  target_column;

  modport source (output valid, opcode, char_code, target_row, target_column,
                  input ready);
  modport sink   (input valid, opcode, char_code, target_row, target_column,
                  output ready);
endinterface

`default_nettype wire

@@ sv/clcd_res_if.sv @@
// Result channel of the character display text buffer.
// Valid/ready handshake with dump cell and status fields; uses clcd_pkg widths.
`default_nettype none

interface clcd_res_if;
  logic                         valid;
  logic                         ready;
  logic                         is_dump;
  logic [clcd_pkg::CH_W-1:0]    cell_char;
  logic [clcd_pkg::IDX_W-1:0]   cell_index;
  logic                         last;
  logic                         ok;
  logic                         pos_error;
  logic [clcd_pkg::ROW_W-1:0]   cursor_row;
  logic [clcd_pkg::COL_W-1:0]   cursor_column;

  modport source (output valid, is_dump, cell_char, cell_index, last, ok,
                  pos_error, cursor_row, cursor_column, input ready);
  modport sink   (input valid, is_dump, cell_char, cell_index, last, ok,
                  pos_error, cursor_row, cursor_column, output ready);
endinterface

`default_nettype wire

@@ sv/char_lcd_text_buffer_core.sv @@
// Character display text buffer (2 x 16 cells) with cursor and position error.
//
// Channels: cmd takes one command item (opcode, char_code, target_row,
// target_column); res returns result items. A command that prints answers
// with 32 items, one per cell in index order, last set on cell 31. A command
// that does not print (unprintable char, set position out of range) answers
// with one status item. Every item of a command carries the cursor, ok and
// the sticky pos_error flag as they stand after the command.
//
// Timing: a small microcode program steps through idle, execute, dump and
// status. A command is taken in the idle step, executes in the next cycle,
// and its cells leave the output register one per cycle while res.ready is
// high; the next command is taken only once its last item has been loaded.
// The single dump pointer sets this rate.
// Reset (synchronous, rst high): all cells hold a space, cursor at row 0
// column 0, error flag clear, output register empty, cmd.ready low.
// Stall: while res.ready is low the current item holds in the output register
// and the sequencer waits; the last item of a command may still wait there
// while the next command is taken.
// Depends on clcd_pkg, clcd_cmd_if, clcd_res_if.
`default_nettype none

module char_lcd_text_buffer_core (
  input  logic        clk,
  input  logic        rst,
  clcd_cmd_if.sink    cmd,
  clcd_res_if.source  res
);

  localparam int unsigned IW = clcd_pkg::IDX_W;
  localparam logic signed [IW+1:0] OFS_ROW = (IW+2)'(clcd_pkg::COLS);
  localparam logic signed [IW+1:0] OFS_ONE = (IW+2)'(1);
  localparam logic signed [IW+1:0] POS_MAX = (IW+2)'(clcd_pkg::CELLS - 1);
  localparam logic [IW-1:0]        IDX_LAST = IW'(clcd_pkg::CELLS - 1);

  // Sequencer
  clcd_pkg::step_t  step, step_next;
  clcd_pkg::ucode_t uc;
  logic             cond_hit;

  // Latched command
  clcd_pkg::opcode_t                 op_q;
  logic [clcd_pkg::CH_W-1:0]         char_q;
  logic [clcd_pkg::TROW_W-1:0]       trow_q;
  logic [clcd_pkg::TCOL_W-1:0]       tcol_q;

  // Buffer and cursor state
  logic [clcd_pkg::CH_W-1:0]   text [clcd_pkg::CELLS];
  logic [clcd_pkg::ROW_W-1:0]  cur_row, cur_row_next;
  logic [clcd_pkg::COL_W-1:0]  cur_col, cur_col_next;
  logic                        error_flag, error_flag_next;
  logic                        ok_q, ok_next;
  logic [IW-1:0]               dump_counter;

  // Output register
  logic                        res_valid;
  logic                        res_is_dump;
  logic [clcd_pkg::CH_W-1:0]   res_char;
  logic [IW-1:0]               res_index;
  logic                        res_last;
  logic                        res_ok;
  logic                        res_err;
  logic [clcd_pkg::ROW_W-1:0]  res_row;
  logic [clcd_pkg::COL_W-1:0]  res_col;

  // Execute datapath
  logic                 printable;
  logic                 set_bad;
  logic                 exec_dump;
  logic                 do_move;
  logic signed [IW+1:0] offset;
  logic signed [IW+1:0] moved;
  logic [IW-1:0]        cur_pos;
  logic [IW-1:0]        new_pos;
  logic                 move_ok;

  logic slot_free;
  logic in_acc;
  logic dump_load;
  logic status_load;

  assign uc        = clcd_pkg::ucode_rom(step);
  assign slot_free = !res_valid || res.ready;
  assign in_acc    = uc.take_in && cmd.valid;
  assign dump_load   = uc.emit_dump && slot_free;
  assign status_load = uc.emit_status && slot_free;

  assign cmd.ready = uc.take_in && !rst;

  assign printable = (char_q >= clcd_pkg::CH_LOW) && (char_q <= clcd_pkg::CH_HIGH);
  assign set_bad   = (trow_q > clcd_pkg::TROW_W'(clcd_pkg::ROWS - 1)) ||
                     (tcol_q > clcd_pkg::TCOL_W'(clcd_pkg::COLS - 1));
  assign exec_dump = !((op_q == clcd_pkg::OP_WRITE && !printable) ||
                       (op_q == clcd_pkg::OP_SET_POS && set_bad));
  assign cur_pos   = IW'(cur_row) * IW'(clcd_pkg::COLS) + IW'(cur_col);

  always_comb begin
    do_move = 1'b0;
    offset  = OFS_ONE;
    unique case (op_q)
      clcd_pkg::OP_WRITE: begin
        do_move = printable;
        offset  = OFS_ONE;
      end
      clcd_pkg::OP_DOWN: begin
        do_move = 1'b1;
        offset  = OFS_ROW;
      end
      clcd_pkg::OP_UP: begin
        do_move = 1'b1;
        offset  = -OFS_ROW;
      end
      clcd_pkg::OP_RIGHT: begin
        do_move = 1'b1;
        offset  = OFS_ONE;
      end
      clcd_pkg::OP_LEFT: begin
        do_move = 1'b1;
        offset  = -OFS_ONE;
      end
      default: begin
        do_move = 1'b0;
        offset  = OFS_ONE;
      end
    endcase
  end

  // Cursor moves work on the flat cell position; rows carry naturally
  always_comb begin
    moved   = $signed({2'b00, cur_pos}) + offset;
    move_ok = 1'b1;
    if (moved < 0) begin
      new_pos = '0;
      move_ok = 1'b0;
    end else if (moved > POS_MAX) begin
      new_pos = IDX_LAST;
      move_ok = 1'b0;
    end else begin
      new_pos = moved[IW-1:0];
    end
  end

  always_comb begin
    cur_row_next    = cur_row;
    cur_col_next    = cur_col;
    error_flag_next = error_flag;
    ok_next         = 1'b1;
    if (do_move) begin
      cur_row_next = clcd_pkg::ROW_W'(new_pos / clcd_pkg::COLS);
      cur_col_next = clcd_pkg::COL_W'(new_pos % clcd_pkg::COLS);
      ok_next      = move_ok;
      if (!move_ok) begin
        error_flag_next = 1'b1;
      end
    end else if (op_q == clcd_pkg::OP_WRITE) begin
      ok_next = 1'b0;   // unprintable, nothing changes
    end else if (op_q == clcd_pkg::OP_CLEAR) begin
      cur_row_next = '0;
      cur_col_next = '0;
    end else if (op_q == clcd_pkg::OP_SET_POS) begin
      if (set_bad) begin
        error_flag_next = 1'b1;
        ok_next         = 1'b0;
      end else begin
        cur_row_next = clcd_pkg::ROW_W'(trow_q);
        cur_col_next = clcd_pkg::COL_W'(tcol_q);
      end
    end
  end

  always_comb begin
    unique case (uc.cond)
      clcd_pkg::COND_IN_ACC:    cond_hit = in_acc;
      clcd_pkg::COND_NO_DUMP:   cond_hit = !exec_dump;
      clcd_pkg::COND_DUMP_DONE: cond_hit = slot_free && (dump_counter == IDX_LAST);
      clcd_pkg::COND_SLOT_FREE: cond_hit = slot_free;
    endcase
    if (cond_hit) begin
      step_next = uc.target;
    end else if (uc.advance) begin
      step_next = step + clcd_pkg::step_t'(1);
    end else begin
      step_next = step;
    end
  end

  // Text store: single write for a char, bulk writes for clears
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < clcd_pkg::CELLS; i++) begin
        text[i] <= clcd_pkg::CH_SPACE;
      end
    end else if (uc.exec) begin
      if (op_q == clcd_pkg::OP_WRITE && printable) begin
        text[cur_pos] <= char_q;
      end else if (op_q == clcd_pkg::OP_CLEAR) begin
        for (int i = 0; i < clcd_pkg::CELLS; i++) begin
          text[i] <= clcd_pkg::CH_SPACE;
        end
      end else if (op_q == clcd_pkg::OP_CLEAR_EOL) begin
        for (int i = 0; i < clcd_pkg::CELLS; i++) begin
          if ((clcd_pkg::ROW_W'(i / clcd_pkg::COLS) == cur_row) &&
              (clcd_pkg::COL_W'(i % clcd_pkg::COLS) >= cur_col)) begin
            text[i] <= clcd_pkg::CH_SPACE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= clcd_pkg::STEP_IDLE;
      cur_row      <= '0;
      cur_col      <= '0;
      error_flag   <= 1'b0;
      ok_q         <= 1'b0;
      dump_counter <= '0;
      res_valid    <= 1'b0;
    end else begin
      step <= step_next;
      if (in_acc) begin
        op_q   <= clcd_pkg::opcode_t'(cmd.opcode);
        char_q <= cmd.char_code;
        trow_q <= cmd.target_row;
        tcol_q <= cmd.target_column;
      end
      if (uc.exec) begin
        cur_row    <= cur_row_next;
        cur_col    <= cur_col_next;
        error_flag <= error_flag_next;
        ok_q       <= ok_next;
      end
      if (dump_load || status_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      if (dump_load) begin
        res_is_dump  <= 1'b1;
        res_char     <= text[dump_counter];
        res_index    <= dump_counter;
        res_last     <= (dump_counter == IDX_LAST);
        dump_counter <= (dump_counter == IDX_LAST) ? '0 : dump_counter + IW'(1);
      end else if (status_load) begin
        res_is_dump <= 1'b0;
        res_char    <= '0;
        res_index   <= '0;
        res_last    <= 1'b1;
      end
      if (dump_load || status_load) begin
        res_ok  <= ok_q;
        res_err <= error_flag;
        res_row <= cur_row;
        res_col <= cur_col;
      end
    end
  end

  assign res.valid         = res_valid;
  assign res.is_dump       = res_is_dump;
  assign res.cell_char     = res_char;
  assign res.cell_index    = res_index;
  assign res.last          = res_last;
  assign res.ok            = res_ok;
  assign res.pos_error     = res_err;
  assign res.cursor_row    = res_row;
  assign res.cursor_column = res_col;

endmodule

`default_nettype wire

@@ sv/clcd_checker.sv @@
// Port-level checks for the character display text buffer.
// Bound to char_lcd_text_buffer_core; depends on clcd_pkg.
`default_nettype none

module clcd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic                        is_dump,
  input logic [clcd_pkg::CH_W-1:0]   cell_char,
  input logic [clcd_pkg::IDX_W-1:0]  cell_index,
  input logic                        last,
  input logic                        ok,
  input logic                        pos_error
);

  localparam logic [clcd_pkg::IDX_W-1:0] IDX_LAST =
    clcd_pkg::IDX_W'(clcd_pkg::CELLS - 1);

  logic                        res_acc;
  logic [clcd_pkg::IDX_W-1:0]  exp_idx;
  logic                        seen_err;

  assign res_acc = res_valid && res_ready;

  // Track the next expected cell and whether an error was ever reported
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx  <= '0;
      seen_err <= 1'b0;
    end else if (res_acc) begin
      if (is_dump) begin
        exp_idx <= (cell_index == IDX_LAST) ? '0 : cell_index + clcd_pkg::IDX_W'(1);
      end
      if (pos_error) begin
        seen_err <= 1'b1;
      end
    end
  end

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid &&
      $stable({is_dump, cell_char, cell_index, last, ok, pos_error}))
    else $error("result item changed while stalled");

  a_dump_order: assert property (@(posedge clk) disable iff (rst)
    res_acc && is_dump |-> cell_index == exp_idx)
    else $error("dump cell out of order");

  a_dump_last: assert property (@(posedge clk) disable iff (rst)
    res_acc && is_dump |-> last == (cell_index == IDX_LAST))
    else $error("last misplaced in dump");

  a_status_form: assert property (@(posedge clk) disable iff (rst)
    res_acc && !is_dump |-> last && !ok && cell_index == '0 &&
      cell_char == '0 && exp_idx == '0)
    else $error("malformed status item");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    res_acc && seen_err |-> pos_error)
    else $error("position error flag dropped");

endmodule

bind char_lcd_text_buffer_core clcd_checker u_clcd_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .is_dump    (res.is_dump),
  .cell_char  (res.cell_char),
  .cell_index (res.cell_index),
  .last       (res.last),
  .ok         (res.ok),
  .pos_error  (res.pos_error)
);

`default_nettype wire

@@ tb/clcd_screen_checker.sv @@
// Checker for the character display text buffer: watches both channels.
// Predicts the cell dump or status item of each command and compares it.
// Depends on clcd_pkg, clcd_cmd_if and clcd_res_if.
`timescale 1ns / 1ps

module clcd_screen_checker
  import clcd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  clcd_cmd_if  cmd,
  clcd_res_if  res,
  output int   fail_count,
  output int   pending
);

  localparam int NROWS  = int'(ROWS);
  localparam int NCOLS  = int'(COLS);
  localparam int NCELLS = int'(CELLS);

  typedef struct packed {
    logic              is_dump;
    logic [CH_W-1:0]   cell_char;
    logic [IDX_W-1:0]  cell_index;
    logic              last;
    logic              ok;
    logic              pos_error;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
  } cell_item_t;

  logic [CH_W-1:0]  screen [NCELLS];
  logic [ROW_W-1:0] crs_row;
  logic [COL_W-1:0] crs_col;
  logic             err_sticky;
  cell_item_t       expected_cells [$];
  int               fails = 0;

  task automatic clear_screen();
    for (int i = 0; i < NCELLS; i++) screen[i] = CH_SPACE;
    crs_row = '0;
    crs_col = '0;
  endtask

  // Move the cursor by at most one row; clamp at either end of the screen.
  function automatic bit move_cursor(int offset);
    int c;
    int r;
    c = int'(crs_col) + offset;
    r = int'(crs_row);
    if (c > NCOLS - 1) begin
      r = r + c / NCOLS;
      c = c % NCOLS;
    end else if (c < 0) begin
      r = r - 1;
      c = c + NCOLS;
    end
    if (r > NROWS - 1) begin
      err_sticky = 1'b1;
      crs_row    = ROW_W'(NROWS - 1);
      crs_col    = COL_W'(NCOLS - 1);
      return 1'b0;
    end
    if (r < 0) begin
      err_sticky = 1'b1;
      crs_row    = '0;
      crs_col    = '0;
      return 1'b0;
    end
    crs_row = ROW_W'(r);
    crs_col = COL_W'(c);
    return 1'b1;
  endfunction

  task automatic run_command(opcode_t op, logic [CH_W-1:0] ch,
                             logic [TROW_W-1:0] trow, logic [TCOL_W-1:0] tcol);
    bit         ok;
    bit         dump;
    cell_item_t item;
    ok   = 1'b1;
    dump = 1'b1;
    case (op)
      OP_WRITE: begin
        if (ch >= CH_LOW && ch <= CH_HIGH) begin
          screen[int'(crs_row) * NCOLS + int'(crs_col)] = ch;
          ok = move_cursor(1);
        end else begin
          ok   = 1'b0;
          dump = 1'b0;
        end
      end
      OP_CLEAR:     clear_screen();
      OP_CLEAR_EOL: begin
        for (int i = int'(crs_col); i < NCOLS; i++)
          screen[int'(crs_row) * NCOLS + i] = CH_SPACE;
      end
      OP_DOWN:  ok = move_cursor(NCOLS);
      OP_UP:    ok = move_cursor(-NCOLS);
      OP_RIGHT: ok = move_cursor(1);
      OP_LEFT:  ok = move_cursor(-1);
      default: begin
        if (int'(trow) > NROWS - 1 || int'(tcol) > NCOLS - 1) begin
          err_sticky = 1'b1;
          ok         = 1'b0;
          dump       = 1'b0;
        end else begin
          crs_row = ROW_W'(trow);
          crs_col = COL_W'(tcol);
        end
      end
    endcase
    item.ok            = ok;
    item.pos_error     = err_sticky;
    item.cursor_row    = crs_row;
    item.cursor_column = crs_col;
    if (!dump) begin
      item.is_dump    = 1'b0;
      item.cell_char  = '0;
      item.cell_index = '0;
      item.last       = 1'b1;
      expected_cells.push_back(item);
    end else begin
      for (int k = 0; k < NCELLS; k++) begin
        item.is_dump    = 1'b1;
        item.cell_char  = screen[k];
        item.cell_index = IDX_W'(k);
        item.last       = (k == NCELLS - 1);
        expected_cells.push_back(item);
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    cell_item_t want;
    if (rst) begin
      clear_screen();
      err_sticky = 1'b0;
      expected_cells.delete();
    end else begin
      // Take the command first: its items are queued behind any still waiting.
      if (cmd.valid && cmd.ready)
        run_command(opcode_t'(cmd.opcode), cmd.char_code, cmd.target_row,
                    cmd.target_column);
      if (res.valid && res.ready) begin
        if (expected_cells.size() == 0) begin
          $error("result item arrived with nothing expected");
          fails++;
        end else begin
          want = expected_cells.pop_front();
          check_field("is_dump", 32'(want.is_dump), 32'(res.is_dump));
          check_field("cell_char", 32'(want.cell_char), 32'(res.cell_char));
          check_field("cell_index", 32'(want.cell_index), 32'(res.cell_index));
          check_field("last", 32'(want.last), 32'(res.last));
          check_field("ok", 32'(want.ok), 32'(res.ok));
          check_field("pos_error", 32'(want.pos_error), 32'(res.pos_error));
          check_field("cursor_row", 32'(want.cursor_row), 32'(res.cursor_row));
          check_field("cursor_column", 32'(want.cursor_column),
                      32'(res.cursor_column));
        end
      end
    end
    fail_count <= fails;
    pending    <= expected_cells.size();
  end

endmodule

@@ tb/tb_char_lcd_text_buffer_core.sv @@
// Top of the character display text buffer testbench: clock, reset, stimulus.
// Drives commands, throttles the result side and gives the verdict.
// Depends on clcd_pkg, both channel interfaces, the block and clcd_screen_checker.
`timescale 1ns / 1ps

module tb_char_lcd_text_buffer_core;
  import clcd_pkg::*;

  localparam int RANDOM_CMDS = 303;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int TAIL_CYCLES = 50;
  localparam int SQUEEZE_AT  = 60;
  localparam int SQUEEZE_LEN = 600;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  int   accepted_cmds = 0;
  int   cycles = 0;

  clcd_cmd_if cmd_ch ();
  clcd_res_if res_ch ();

  char_lcd_text_buffer_core dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  clcd_screen_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Keep the sender busy around the long receiver hold-off and in one further stretch.
  function automatic int sender_gap();
    int r;
    if ((accepted_cmds >= SQUEEZE_AT - 2 && accepted_cmds < SQUEEZE_AT + 20) ||
        (accepted_cmds >= 110 && accepted_cmds < 150))
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_cmd(opcode_t op, logic [CH_W-1:0] ch,
                          logic [TROW_W-1:0] trow, logic [TCOL_W-1:0] tcol);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.opcode        <= op;
    cmd_ch.char_code     <= ch;
    cmd_ch.target_row    <= trow;
    cmd_ch.target_column <= tcol;
    do @(posedge clk); while (!cmd_ch.ready);
    accepted_cmds++;
  endtask

  // Control command with random noise in the fields it ignores.
  task automatic send_ctrl(opcode_t op);
    send_cmd(op, CH_W'($urandom), TROW_W'($urandom), TCOL_W'($urandom));
  endtask

  task automatic send_char(logic [CH_W-1:0] ch);
    send_cmd(OP_WRITE, ch, TROW_W'($urandom), TCOL_W'($urandom));
  endtask

  task automatic send_pos(logic [TROW_W-1:0] trow, logic [TCOL_W-1:0] tcol);
    send_cmd(OP_SET_POS, CH_W'($urandom), trow, tcol);
  endtask

  task automatic random_cmd();
    int               p;
    logic [CH_W-1:0]  ch;
    logic [TROW_W-1:0] trow;
    logic [TCOL_W-1:0] tcol;
    p    = $urandom_range(0, 99);
    ch   = CH_W'($urandom);
    trow = TROW_W'($urandom);
    tcol = TCOL_W'($urandom);
    if (p < 40) begin
      if ($urandom_range(0, 9) < 8)
        ch = CH_W'($urandom_range(int'(CH_LOW), int'(CH_HIGH)));
      else if ($urandom_range(0, 1) == 0)
        ch = CH_W'($urandom_range(0, int'(CH_LOW) - 1));
      else
        ch = CH_W'($urandom_range(int'(CH_HIGH) + 1, 255));
      send_cmd(OP_WRITE, ch, trow, tcol);
    end else if (p < 44) send_cmd(OP_CLEAR, ch, trow, tcol);
    else if (p < 51) send_cmd(OP_CLEAR_EOL, ch, trow, tcol);
    else if (p < 59) send_cmd(OP_DOWN, ch, trow, tcol);
    else if (p < 67) send_cmd(OP_UP, ch, trow, tcol);
    else if (p < 79) send_cmd(OP_RIGHT, ch, trow, tcol);
    else if (p < 90) send_cmd(OP_LEFT, ch, trow, tcol);
    else begin
      if ($urandom_range(0, 3) != 0) begin
        trow = TROW_W'($urandom_range(0, int'(ROWS) - 1));
        tcol = TCOL_W'($urandom_range(0, int'(COLS) - 1));
      end
      send_cmd(OP_SET_POS, ch, trow, tcol);
    end
  endtask

  // Result side: random stalls, one quiet stretch and one long hold-off.
  initial begin
    int  stall;
    int  r;
    bit  squeezed;
    stall    = 0;
    squeezed = 1'b0;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!squeezed && accepted_cmds >= SQUEEZE_AT) begin
        squeezed = 1'b1;
        stall    = SQUEEZE_LEN;
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        stall--;
      end else begin
        res_ch.ready <= 1'b1;
        if (accepted_cmds < 170 || accepted_cmds >= 220) begin
          r = $urandom_range(0, 99);
          if (r < 15) stall = $urandom_range(1, 3);
          else if (r < 17) stall = $urandom_range(10, 40);
        end
      end
      @(posedge clk);
    end
  end

  initial begin
    rst                  <= 1'b1;
    cmd_ch.valid         <= 1'b0;
    cmd_ch.opcode        <= OP_WRITE;
    cmd_ch.char_code     <= '0;
    cmd_ch.target_row    <= '0;
    cmd_ch.target_column <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Printable range edges and unprintable bytes, before any position error.
    send_char(8'd65);
    send_char(CH_LOW);
    send_char(CH_HIGH);
    send_char(CH_LOW - 8'd1);
    send_char(CH_HIGH + 8'd1);
    send_char(8'd0);
    send_char(8'd255);
    // Carry across rows in both directions.
    send_pos(4'd0, 6'd15);
    send_char(8'd90);
    send_ctrl(OP_LEFT);
    send_ctrl(OP_RIGHT);
    send_ctrl(OP_UP);
    send_ctrl(OP_DOWN);
    send_pos(4'd0, 6'd3);
    send_ctrl(OP_CLEAR_EOL);
    send_ctrl(OP_CLEAR);
    // Clamps at the last and first cell set the sticky error.
    send_pos(4'd1, 6'd15);
    send_char(8'd126);
    send_ctrl(OP_RIGHT);
    send_ctrl(OP_DOWN);
    send_pos(4'd0, 6'd0);
    send_ctrl(OP_LEFT);
    send_ctrl(OP_UP);
    // Out-of-range set position leaves the cursor alone; a valid one then moves it.
    send_pos(4'd2, 6'd0);
    send_pos(4'd15, 6'd63);
    send_pos(4'd0, 6'd16);
    send_pos(4'd1, 6'd0);

    repeat (RANDOM_CMDS) random_cmd();
    cmd_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/clcd_pkg.sv
sv/clcd_cmd_if.sv
sv/clcd_res_if.sv
sv/char_lcd_text_buffer_core.sv
sv/clcd_checker.sv
tb/clcd_screen_checker.sv
tb/tb_char_lcd_text_buffer_core.sv
